// File: rtl/rmth_pkg.sv
package rmth_pkg;

    localparam int CAPACITY_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MEDIAN_BITS     = 16;
    localparam int COUNT_BITS      = 11;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input, start item
        logic clear;      // empty both heaps
        logic route;      // decide placement from tops
        logic push_start; // begin sift-up
        logic push_step;  // one sift-up phase
        logic repl_start; // begin sift-down
        logic repl_step;  // one sift-down phase
        logic finish;     // never driven; the result is formed combinationally
    } rmth_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_clear;
        logic full;
        logic need_repl;
        logic push_done;
        logic repl_done;
    } rmth_sts_t;

endpackage

// File: rtl/running_median_two_heaps.sv
// Running median over signed samples held in a max-heap (lower half) and a
// min-heap (upper half), each in its own single-port-write memory.
// Input channel s_valid/s_ready carries s_operation (0 insert, 1 clear) and
// s_sample. Result channel m_valid/m_ready carries m_median, m_sample_count,
// m_dropped; one result per input transfer.
// One item at a time. After the input transfer, a clear or a dropped insert
// goes straight to the result. An insert is routed from the two tops; when
// it displaces a top, the input first sifts down from that heap's top, then
// the displaced top sifts up in the other heap; otherwise the input sifts up.
// Each sift level is a registered memory read, then compare/write. At CAPACITY
// 1024, each sift moves at most 8 levels; the next input transfer can follow
// in the cycle after the result transfer.
// s_ready is high only while the block is idle; a stalled m_ready holds the
// result and the block until the transfer completes.
// Reset (aresetn low, synchronous) empties both heaps; heap memories are not
// cleared and need no clearing pass.
module running_median_two_heaps
    import rmth_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [MEDIAN_BITS-1:0] m_median,
    output logic [COUNT_BITS-1:0]         m_sample_count,
    output logic                          m_dropped
);

    rmth_cmd_t cmd;
    rmth_sts_t sts;

    rmth_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    rmth_datapath #(
        .CAPACITY    (CAPACITY),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .in_operation (s_operation),
        .in_sample    (s_sample),
        .res_median   (m_median),
        .res_count    (m_sample_count),
        .res_dropped  (m_dropped)
    );

endmodule

// File: rtl/rmth_datapath.sv
module rmth_datapath
    import rmth_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rmth_cmd_t                     cmd,
    output rmth_sts_t                     sts,
    input  logic                          in_operation,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    output logic signed [MEDIAN_BITS-1:0] res_median,
    output logic [COUNT_BITS-1:0]         res_count,
    output logic                          res_dropped
);

    localparam int LDEPTH = (CAPACITY + 1) / 2;
    localparam int UDEPTH = (CAPACITY > 1) ? CAPACITY / 2 : 1;
    localparam int AW     = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
    localparam int SW     = $clog2(LDEPTH + 1);
    localparam int TW     = $clog2(CAPACITY + 1);

    logic signed [SAMPLE_BITS-1:0] lmem [LDEPTH];
    logic signed [SAMPLE_BITS-1:0] umem [UDEPTH];

    logic [SW-1:0] lsize_reg, lsize_next, usize_reg, usize_next;
    logic signed [SAMPLE_BITS-1:0] ltop_reg, ltop_next, utop_reg, utop_next;
    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic op_reg, op_next;
    logic drop_reg, drop_next;

    // sift engines state
    logic          ph_reg, ph_next;      // push heap: 0 lower, 1 upper
    logic          rh_reg, rh_next;      // replace heap
    logic          need_repl_reg, need_repl_next;
    logic signed [SAMPLE_BITS-1:0] pv_reg, pv_next, rv_reg, rv_next;
    logic [AW-1:0] pi_reg, pi_next, ri_reg, ri_next;
    logic [SW-1:0] rsize_reg, rsize_next;
    logic [1:0]    rph_reg, rph_next;
    logic          pph_reg, pph_next;
    logic          pdone_reg, pdone_next, rdone_reg, rdone_next;

    logic signed [SAMPLE_BITS-1:0] lrd_reg, urd_reg, lrd2_reg, urd2_reg;
    logic          we_l, we_u;
    logic [AW-1:0] wa_l, wa_u, ra_l, ra_u, rb_l, rb_u;
    logic signed [SAMPLE_BITS-1:0] wd_l, wd_u;

    logic [TW-1:0] total;
    logic [AW-1:0] pparent, rl, rr;
    logic signed [SAMPLE_BITS-1:0] pcur, c1, c2, rbest_v;
    logic [AW-1:0] rbest_i;
    logic          l_ok, r_ok, pmove;
    logic [AW+1:0] rl_w, rr_w;
    logic signed [SAMPLE_BITS:0] sum_t;
    logic signed [SAMPLE_BITS:0] mean_t;

    assign total = TW'(lsize_reg) + TW'(usize_reg);

    assign pparent = (pi_reg - AW'(1)) >> 1;
    assign pcur    = ph_reg ? urd_reg : lrd_reg;
    assign pmove   = ph_reg ? (pv_reg < pcur) : (pv_reg > pcur);

    assign rl_w = {1'b0, ri_reg, 1'b1};
    assign rr_w = rl_w + (AW+2)'(1);
    assign rl   = rl_w[AW-1:0];
    assign rr   = rr_w[AW-1:0];
    assign c1   = rh_reg ? urd_reg  : lrd_reg;
    assign c2   = rh_reg ? urd2_reg : lrd2_reg;
    assign l_ok = (SW+2)'(rl_w) < (SW+2)'(rsize_reg);
    assign r_ok = (SW+2)'(rr_w) < (SW+2)'(rsize_reg);

    always_comb begin
        rbest_v = rv_reg;
        rbest_i = ri_reg;
        if (l_ok && (rh_reg ? (c1 < rbest_v) : (c1 > rbest_v))) begin
            rbest_v = c1;
            rbest_i = rl;
        end
        if (r_ok && (rh_reg ? (c2 < rbest_v) : (c2 > rbest_v))) begin
            rbest_v = c2;
            rbest_i = rr;
        end
    end

    always_comb begin
        we_l = 1'b0; we_u = 1'b0;
        wa_l = '0; wa_u = '0; wd_l = pv_reg; wd_u = pv_reg;
        ra_l = '0; ra_u = '0; rb_l = '0; rb_u = '0;
        if (cmd.push_step && pph_reg) begin
            if (pi_reg != '0 && pmove) begin
                if (ph_reg) begin
                    we_u = 1'b1; wa_u = pi_reg; wd_u = pcur;
                end else begin
                    we_l = 1'b1; wa_l = pi_reg; wd_l = pcur;
                end
            end else begin
                if (ph_reg) begin
                    we_u = 1'b1; wa_u = pi_reg; wd_u = pv_reg;
                end else begin
                    we_l = 1'b1; wa_l = pi_reg; wd_l = pv_reg;
                end
            end
        end else if (cmd.repl_step && rph_reg == 2'd1) begin
            if (rh_reg) begin
                we_u = 1'b1; wa_u = ri_reg; wd_u = rbest_v;
            end else begin
                we_l = 1'b1; wa_l = ri_reg; wd_l = rbest_v;
            end
        end
        if (cmd.push_step && !pph_reg) begin
            ra_l = pparent; ra_u = pparent;
        end
        if (cmd.repl_step && rph_reg == 2'd0) begin
            ra_l = rl; ra_u = rl; rb_l = rr; rb_u = rr;
        end
    end

    always_ff @(posedge aclk) begin
        if (we_l) lmem[wa_l] <= wd_l;
        if (we_u) umem[wa_u] <= wd_u;
        lrd_reg  <= lmem[ra_l];
        lrd2_reg <= lmem[rb_l];
        urd_reg  <= umem[ra_u];
        urd2_reg <= umem[rb_u];
    end

    always_comb begin
        lsize_next = lsize_reg; usize_next = usize_reg;
        ltop_next = ltop_reg; utop_next = utop_reg;
        x_next = x_reg; op_next = op_reg; drop_next = drop_reg;
        ph_next = ph_reg; rh_next = rh_reg; need_repl_next = need_repl_reg;
        pv_next = pv_reg; pi_next = pi_reg; rv_next = rv_reg; ri_next = ri_reg;
        rsize_next = rsize_reg; rph_next = rph_reg; pph_next = pph_reg;
        pdone_next = pdone_reg; rdone_next = rdone_reg;
        if (cmd.load) begin
            x_next = in_sample; op_next = in_operation;
            drop_next = 1'b0; pdone_next = 1'b0; rdone_next = 1'b0;
        end
        if (cmd.clear) begin
            lsize_next = '0; usize_next = '0;
        end
        if (cmd.route) begin
            drop_next = total >= TW'(CAPACITY);
            need_repl_next = 1'b0;
            if (lsize_reg == usize_reg) begin
                ph_next = 1'b0;
                if (usize_reg == '0 || x_reg <= utop_reg) begin
                    pv_next = x_reg;
                end else begin
                    pv_next = utop_reg; rv_next = x_reg;
                    rh_next = 1'b1; need_repl_next = 1'b1;
                end
            end else begin
                ph_next = 1'b1;
                if (x_reg >= ltop_reg) begin
                    pv_next = x_reg;
                end else begin
                    pv_next = ltop_reg; rv_next = x_reg;
                    rh_next = 1'b0; need_repl_next = 1'b1;
                end
            end
        end
        if (cmd.repl_start) begin
            ri_next = '0; rph_next = 2'd0;
            rsize_next = rh_reg ? usize_reg : lsize_reg;
            if (rh_reg) utop_next = rv_reg; else ltop_next = rv_reg;
        end
        if (cmd.repl_step) begin
            if (rph_reg == 2'd0) begin
                rph_next = 2'd1;
            end else begin
                if (rbest_i == ri_reg) begin
                    rdone_next = 1'b1;
                end else begin
                    ri_next = rbest_i; rph_next = 2'd0;
                    if (ri_reg == '0) begin
                        if (rh_reg) utop_next = rbest_v; else ltop_next = rbest_v;
                    end
                end
            end
        end
        if (cmd.push_start) begin
            pi_next = ph_reg ? usize_reg[AW-1:0] : lsize_reg[AW-1:0];
            pph_next = 1'b0;
            if (ph_reg) usize_next = usize_reg + SW'(1);
            else        lsize_next = lsize_reg + SW'(1);
        end
        if (cmd.push_step) begin
            if (!pph_reg) begin
                pph_next = 1'b1;
            end else if (pi_reg != '0 && pmove) begin
                pi_next = pparent; pph_next = 1'b0;
            end else begin
                pdone_next = 1'b1;
                if (pi_reg == '0) begin
                    if (ph_reg) utop_next = pv_reg; else ltop_next = pv_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lsize_reg <= '0;
            usize_reg <= '0;
            pdone_reg <= 1'b0;
            rdone_reg <= 1'b0;
            pph_reg   <= 1'b0;
            rph_reg   <= 2'd0;
        end else begin
            lsize_reg <= lsize_next;
            usize_reg <= usize_next;
            pdone_reg <= pdone_next;
            rdone_reg <= rdone_next;
            pph_reg   <= pph_next;
            rph_reg   <= rph_next;
        end
        ltop_reg <= ltop_next; utop_reg <= utop_next;
        x_reg <= x_next; op_reg <= op_next; drop_reg <= drop_next;
        ph_reg <= ph_next; rh_reg <= rh_next; need_repl_reg <= need_repl_next;
        pv_reg <= pv_next; pi_reg <= pi_next; rv_reg <= rv_next; ri_reg <= ri_next;
        rsize_reg <= rsize_next;
    end

    assign sts.is_clear  = op_reg == OP_CLEAR;
    assign sts.full      = total >= TW'(CAPACITY);
    assign sts.need_repl = need_repl_reg;
    assign sts.push_done = pdone_reg;
    assign sts.repl_done = rdone_reg;

    assign sum_t  = (SAMPLE_BITS+1)'(ltop_reg) + (SAMPLE_BITS+1)'(utop_reg);
    assign mean_t = (sum_t + ((sum_t < 0) ? (SAMPLE_BITS+1)'(1) : '0)) >>> 1;

    always_comb begin
        if (lsize_reg == '0)
            res_median = '0;
        else if (lsize_reg > usize_reg || usize_reg == '0)
            res_median = MEDIAN_BITS'(ltop_reg);
        else
            res_median = MEDIAN_BITS'(mean_t);
    end
    assign res_count   = COUNT_BITS'(total);
    assign res_dropped = drop_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) usize_reg <= lsize_reg)
        else $error("upper heap larger than lower");
    assert property (@(posedge aclk) disable iff (!aresetn)
                     lsize_reg <= usize_reg + SW'(1))
        else $error("heaps out of balance");
    assert property (@(posedge aclk) disable iff (!aresetn)
                     !(cmd.push_step && cmd.repl_step))
        else $error("both sift engines active");

endmodule

// File: rtl/rmth_ctrl.sv
module rmth_ctrl
    import rmth_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output rmth_cmd_t cmd,
    input  rmth_sts_t sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_ROUTE = 3'd2;
    localparam logic [2:0] S_REPL  = 3'd3;
    localparam logic [2:0] S_PUSHS = 3'd4;
    localparam logic [2:0] S_PUSH  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE: if (in_valid) begin
                cmd.load = 1'b1; state_next = S_DEC;
            end
            S_DEC: begin
                if (sts.is_clear) begin
                    cmd.clear = 1'b1; state_next = S_OUT;
                end else if (sts.full) begin
                    cmd.route = 1'b1; state_next = S_OUT;
                end else begin
                    cmd.route = 1'b1; state_next = S_ROUTE;
                end
            end
            S_ROUTE: begin
                if (sts.need_repl) begin
                    cmd.repl_start = 1'b1; state_next = S_REPL;
                end else begin
                    state_next = S_PUSHS;
                end
            end
            S_REPL: begin
                if (sts.repl_done) state_next = S_PUSHS;
                else cmd.repl_step = 1'b1;
            end
            S_PUSHS: begin
                cmd.push_start = 1'b1; state_next = S_PUSH;
            end
            S_PUSH: begin
                if (sts.push_done) state_next = S_OUT;
                else cmd.push_step = 1'b1;
            end
            S_OUT: if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

endmodule
